// ----- hw/rtl/tccw_pkg.sv -----
// Shared types and constants for the text console cell writer.
// Holds command codes, decoded operation codes and the payload structs.
// No dependencies.
`timescale 1ns / 1ps

package tccw_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // special character bytes and cell values
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_TAB     = 8'd9;
  localparam logic [7:0]  CHAR_SPACE   = 8'd32;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  ATTR_RESET   = 8'd7;

  // operation classes decided at the front end
  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_NEWLINE,
    OP_TAB,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_index;
  } out_item_t;

  // entry of the queue between front and back
  typedef struct packed {
    op_t         op;
    logic [7:0]  char_code;
    logic [10:0] read_address;
  } op_item_t;

endpackage

// ----- hw/rtl/text_console_cell_writer_core.sv -----
// Top level of the text console cell writer: attribute register, front end,
// queue and back end. Depends on tccw_pkg, tccw_front, tccw_queue, tccw_back.
//
// Usage:
//   Input: drive in_item and raise start; the command transfers at a rising
//   edge with start high and busy low. Commands are put character, read cell
//   and clear screen. Up to two commands wait in a queue while the back end
//   works, so busy rises when that queue is full and during the reset sweep.
//   Output: every command yields exactly one result, shown on out_item for one
//   cycle with out_valid high. The receiver cannot stall; it must take it.
//   Configuration: cfg_we with cfg_wdata sets the text attribute; write it
//   only while no command is in flight.
//   The back end handles one command at a time through its single write
//   port: a tab writes its spaces one after another, a scroll blanks the
//   new bottom row cell by cell, and a clear sweeps every screen cell. The
//   queue lets new commands transfer while the back end is still busy with
//   an earlier one.
//   Reset: the screen memory is swept to blank grey cells, one cell per cycle,
//   with busy held high; the cursor homes and the attribute returns to 0x07.
`timescale 1ns / 1ps

module text_console_cell_writer_core #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tccw_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tccw_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  logic               attr_r;
  logic [7:0]         text_attr_r;
  logic               push;
  tccw_pkg::op_item_t push_item;
  logic               q_full;
  logic               q_valid;
  tccw_pkg::op_item_t q_item;
  logic               q_pop;
  logic               init_busy;

  // capture the attribute register on a configuration transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tccw_pkg::ATTR_RESET;
      attr_r      <= 1'b0;
    end else if (cfg_we) begin
      text_attr_r <= cfg_wdata;
      attr_r      <= 1'b1;
    end
  end

  tccw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .start     (start),
    .in_item   (in_item),
    .q_full    (q_full),
    .init_busy (init_busy),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  tccw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tccw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_STOP      (TAB_STOP)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_attribute (text_attr_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_item       (out_item)
  );

  a_cfg_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (attr_r && cfg_we) |-> !q_valid)
    else $error("attribute written while commands are queued");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> busy)
    else $error("command accepted during screen sweep");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_valid)
    else $error("transferred command missing from queue");

endmodule

// ----- hw/rtl/tccw_front.sv -----
// Front end of the text console cell writer: accepts commands and classifies them.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_front #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                start,
  input  tccw_pkg::in_item_t  in_item,
  input  logic                q_full,
  input  logic                init_busy,
  output logic                busy,
  output logic                push,
  output tccw_pkg::op_item_t  push_item
);

  localparam int CellCount = SCREEN_WIDTH * SCREEN_HEIGHT;

  // hold off while the queue is full or the reset sweep of the screen runs
  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  // classify the command into one back-end operation
  always_comb begin
    push_item.char_code    = in_item.char_code;
    push_item.read_address = in_item.read_address;
    case (in_item.cmd)
      tccw_pkg::CMD_PUT: begin
        if (in_item.char_code == tccw_pkg::CHAR_NEWLINE) begin
          push_item.op = tccw_pkg::OP_NEWLINE;
        end else if (in_item.char_code == tccw_pkg::CHAR_TAB) begin
          push_item.op = tccw_pkg::OP_TAB;
        end else begin
          push_item.op = tccw_pkg::OP_GLYPH;
        end
      end
      tccw_pkg::CMD_READ: begin
        // an address past the screen reads as zero and changes nothing
        if (int'(in_item.read_address) < CellCount) begin
          push_item.op = tccw_pkg::OP_READ;
        end else begin
          push_item.op = tccw_pkg::OP_NOP;
        end
      end
      tccw_pkg::CMD_CLEAR: push_item.op = tccw_pkg::OP_CLEAR;
      default:             push_item.op = tccw_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/tccw_queue.sv -----
// Two-entry queue of classified operations between front and back end.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tccw_pkg::op_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               q_valid,
  output tccw_pkg::op_item_t q_item
);

  localparam int Depth = 2;

  tccw_pkg::op_item_t slot_r [Depth];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;

  assign full    = (cnt_r == 2'(Depth));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

  // store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(Depth))
    else $error("queue count out of range");

endmodule

// ----- hw/rtl/tccw_back.sv -----
// Back end of the text console cell writer: screen memory, cursor and sequencer.
// Scrolls through a ring row offset; depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_back #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          text_attribute,
  input  logic                q_valid,
  input  tccw_pkg::op_item_t  q_item,
  output logic                q_pop,
  output logic                init_busy,
  output logic                out_valid,
  output tccw_pkg::out_item_t out_item
);

  localparam int CellCount = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW     = $clog2(CellCount);
  localparam int RdW       = AddrW + 1;
  localparam int ColW      = $clog2(SCREEN_WIDTH);
  localparam int RowW      = $clog2(SCREEN_HEIGHT);
  localparam int TphW      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TabW      = $clog2(TAB_STOP + 1);

  localparam logic [AddrW-1:0] LastAddr    = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] LastRowBase = AddrW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [AddrW-1:0] RowStep     = AddrW'(SCREEN_WIDTH);
  localparam logic [ColW-1:0]  LastCol     = ColW'(SCREEN_WIDTH - 1);
  localparam logic [RowW-1:0]  LastRow     = RowW'(SCREEN_HEIGHT - 1);
  localparam logic [TphW-1:0]  LastTph     = TphW'(TAB_STOP - 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_GLYPH,
    S_FILL,
    S_CLEAR,
    S_READ_WAIT,
    S_READ_DONE,
    S_DONE
  } state_t;

  state_t             state_r;
  tccw_pkg::op_item_t cur_r;
  logic [RowW-1:0]    row_r;
  logic [ColW-1:0]    col_r;
  logic [TphW-1:0]    tph_r;
  logic [AddrW-1:0]   rowbase_r;   // logical row * width, for the cursor index
  logic [AddrW-1:0]   base_r;      // physical base of the cursor row
  logic [AddrW-1:0]   topbase_r;   // physical base of the top screen row
  logic [7:0]         glyph_ch_r;
  logic [TabW-1:0]    tab_left_r;
  logic [ColW-1:0]    fill_cnt_r;
  logic [AddrW-1:0]   clr_addr_r;
  logic [AddrW-1:0]   rd_addr_r;
  logic [15:0]        rd_data_r;
  logic [15:0]        cell_r;
  logic               out_valid_r;
  tccw_pkg::out_item_t out_item_r;

  logic [15:0]        mem [CellCount];

  logic               last_row;
  logic               last_col;
  logic [RowW-1:0]    row_adv;
  logic [AddrW-1:0]   rowbase_adv;
  logic [AddrW-1:0]   base_adv;
  logic [AddrW-1:0]   top_adv;
  logic [TphW-1:0]    tph_inc;
  logic [TabW-1:0]    left_dec;
  logic [TabW-1:0]    tab_n;
  logic [RdW-1:0]     rd_sum;
  logic [AddrW-1:0]   rd_phys;
  logic [AddrW-1:0]   idx_sum;
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa;
  logic [15:0]        mem_wd;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // next-row values for a newline or a wrap, with ring scroll of the top row
  always_comb begin
    last_row    = (row_r == LastRow);
    last_col    = (col_r == LastCol);
    row_adv     = last_row ? row_r : row_r + RowW'(1);
    rowbase_adv = last_row ? rowbase_r : rowbase_r + RowStep;
    base_adv    = (base_r == LastRowBase) ? '0 : base_r + RowStep;
    top_adv     = (topbase_r == LastRowBase) ? '0 : topbase_r + RowStep;
    tph_inc     = (tph_r == LastTph) ? '0 : tph_r + TphW'(1);
    left_dec    = tab_left_r - TabW'(1);
    tab_n       = TabW'(TAB_STOP) - TabW'(tph_r);
    idx_sum     = rowbase_r + AddrW'(col_r);
  end

  // map a logical read address onto the ring
  always_comb begin
    rd_sum  = RdW'(cur_r.read_address) + {1'b0, topbase_r};
    if (rd_sum >= RdW'(CellCount)) begin
      rd_phys = AddrW'(rd_sum - RdW'(CellCount));
    end else begin
      rd_phys = AddrW'(rd_sum);
    end
  end

  // select the write port source
  always_comb begin
    mem_we = 1'b0;
    mem_wa = base_r + AddrW'(col_r);
    mem_wd = {text_attribute, glyph_ch_r};
    case (state_r)
      S_GLYPH: begin
        mem_we = 1'b1;
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = base_r + AddrW'(fill_cnt_r);
        mem_wd = {text_attribute, tccw_pkg::CHAR_SPACE};
      end
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = tccw_pkg::BLANK_CELL;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_addr_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      tph_r       <= '0;
      rowbase_r   <= '0;
      base_r      <= '0;
      topbase_r   <= '0;
      tab_left_r  <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          cell_r <= '0;
          case (cur_r.op)
            tccw_pkg::OP_GLYPH: begin
              glyph_ch_r <= cur_r.char_code;
              tab_left_r <= TabW'(1);
              state_r    <= S_GLYPH;
            end
            tccw_pkg::OP_TAB: begin
              glyph_ch_r <= tccw_pkg::CHAR_SPACE;
              tab_left_r <= tab_n;
              state_r    <= S_GLYPH;
            end
            tccw_pkg::OP_NEWLINE: begin
              tab_left_r <= '0;
              col_r      <= '0;
              tph_r      <= '0;
              row_r      <= row_adv;
              rowbase_r  <= rowbase_adv;
              base_r     <= base_adv;
              if (last_row) begin
                topbase_r  <= top_adv;
                fill_cnt_r <= '0;
                state_r    <= S_FILL;
              end else begin
                state_r <= S_DONE;
              end
            end
            tccw_pkg::OP_READ: begin
              rd_addr_r <= rd_phys;
              state_r   <= S_READ_WAIT;
            end
            tccw_pkg::OP_CLEAR: begin
              clr_addr_r <= '0;
              state_r    <= S_CLEAR;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end

        // write one glyph and step the cursor, wrapping at the last column
        S_GLYPH: begin
          tab_left_r <= left_dec;
          if (last_col) begin
            col_r     <= '0;
            tph_r     <= '0;
            row_r     <= row_adv;
            rowbase_r <= rowbase_adv;
            base_r    <= base_adv;
            if (last_row) begin
              topbase_r  <= top_adv;
              fill_cnt_r <= '0;
              state_r    <= S_FILL;
            end else begin
              state_r <= (left_dec != '0) ? S_GLYPH : S_DONE;
            end
          end else begin
            col_r   <= col_r + ColW'(1);
            tph_r   <= tph_inc;
            state_r <= (left_dec != '0) ? S_GLYPH : S_DONE;
          end
        end

        // blank the row that scrolled in at the bottom
        S_FILL: begin
          if (fill_cnt_r == LastCol) begin
            state_r <= (tab_left_r != '0) ? S_GLYPH : S_DONE;
          end else begin
            fill_cnt_r <= fill_cnt_r + ColW'(1);
          end
        end

        // sweep the whole screen, then home the cursor
        S_INIT, S_CLEAR: begin
          if (clr_addr_r == LastAddr) begin
            row_r     <= '0;
            col_r     <= '0;
            tph_r     <= '0;
            rowbase_r <= '0;
            base_r    <= '0;
            topbase_r <= '0;
            state_r   <= (state_r == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            clr_addr_r <= clr_addr_r + AddrW'(1);
          end
        end

        S_READ_WAIT: begin
          state_r <= S_READ_DONE;
        end

        S_READ_DONE: begin
          cell_r  <= rd_data_r;
          state_r <= S_DONE;
        end

        // present the result for one cycle
        S_DONE: begin
          out_valid_r                <= 1'b1;
          out_item_r.cell_value      <= cell_r;
          out_item_r.cursor_row      <= 5'(row_r);
          out_item_r.cursor_column   <= 7'(col_r);
          out_item_r.cursor_index    <= 11'(idx_sum);
          state_r                    <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_wa) < CellCount))
    else $error("screen write address out of range");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < SCREEN_HEIGHT) && (int'(col_r) < SCREEN_WIDTH))
    else $error("cursor outside the screen");

  a_glyph_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GLYPH) |-> (tab_left_r != '0))
    else $error("glyph step with no glyph left");

  a_pop_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_EXEC))
    else $error("popped operation not dispatched");

endmodule

// ----- bench/console_screen_checker.sv -----
// Checker for the text console cell writer: watches command, result and
// attribute transfers, keeps its own copy of the screen and cursor, and
// compares every result with the oldest outstanding prediction. Uses tccw_pkg.
`timescale 1ns / 1ps

module console_screen_checker #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  tccw_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  tccw_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output int                  mismatch_count,
  output int                  reports_owed
);

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;

  // shadow screen, cursor and attribute
  logic [15:0] screen [CELL_COUNT];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  attribute;

  tccw_pkg::out_item_t awaited_reports [$];
  tccw_pkg::out_item_t oldest;
  int                  mismatch_tally = 0;

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELL_COUNT; i++) screen[i] = tccw_pkg::BLANK_CELL;
  endfunction

  // move to column 0 of the next row, scroll up when leaving the bottom row
  function automatic void line_feed();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_HEIGHT) begin
      for (i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++) screen[i] = screen[i + SCREEN_WIDTH];
      cur_row = SCREEN_HEIGHT - 1;
      for (i = 0; i < SCREEN_WIDTH; i++)
        screen[cur_row * SCREEN_WIDTH + i] = {attribute, tccw_pkg::CHAR_SPACE};
    end
  endfunction

  // store one character at the cursor and advance, wrapping at the last column
  function automatic void store_glyph(logic [7:0] ch);
    screen[cur_row * SCREEN_WIDTH + cur_col] = {attribute, ch};
    cur_col++;
    if (cur_col >= SCREEN_WIDTH) line_feed();
  endfunction

  // apply one command to the shadow screen and return the cursor report
  function automatic tccw_pkg::out_item_t console_step(tccw_pkg::in_item_t c);
    tccw_pkg::out_item_t r;
    logic [15:0]         cell_word;
    int                  spaces;
    int                  i;
    cell_word = '0;
    case (c.cmd)
      tccw_pkg::CMD_PUT: begin
        if (c.char_code == tccw_pkg::CHAR_NEWLINE) begin
          line_feed();
        end else if (c.char_code == tccw_pkg::CHAR_TAB) begin
          spaces = TAB_STOP - int'(cur_col % TAB_STOP);
          for (i = 0; i < spaces; i++) store_glyph(tccw_pkg::CHAR_SPACE);
        end else begin
          store_glyph(c.char_code);
        end
      end
      tccw_pkg::CMD_READ: begin
        if (c.read_address < CELL_COUNT) cell_word = screen[c.read_address];
      end
      tccw_pkg::CMD_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    r.cell_value    = cell_word;
    r.cursor_row    = cur_row[4:0];
    r.cursor_column = cur_col[6:0];
    r.cursor_index  = 11'(cur_row * SCREEN_WIDTH + cur_col);
    return r;
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_tally++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // check results first, then take attribute writes and new commands
  always @(posedge clk) begin
    if (!rst_n) begin
      attribute = tccw_pkg::ATTR_RESET;
      cur_row   = 0;
      cur_col   = 0;
      blank_screen();
      awaited_reports.delete();
    end else begin
      if (out_valid) begin
        if (awaited_reports.size() == 0) begin
          mismatch_tally++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          oldest = awaited_reports.pop_front();
          if (out_item.cell_value != oldest.cell_value)
            note_mismatch("cell_value", 32'(oldest.cell_value), 32'(out_item.cell_value));
          if (out_item.cursor_row != oldest.cursor_row)
            note_mismatch("cursor_row", 32'(oldest.cursor_row), 32'(out_item.cursor_row));
          if (out_item.cursor_column != oldest.cursor_column)
            note_mismatch("cursor_column", 32'(oldest.cursor_column),
                          32'(out_item.cursor_column));
          if (out_item.cursor_index != oldest.cursor_index)
            note_mismatch("cursor_index", 32'(oldest.cursor_index),
                          32'(out_item.cursor_index));
        end
      end
      if (cfg_we) attribute = cfg_wdata;
      if (start && !busy) awaited_reports.push_back(console_step(in_item));
    end
    reports_owed   <= awaited_reports.size();
    mismatch_count <= mismatch_tally;
  end

endmodule

// ----- bench/tb.sv -----
// Top of the text console cell writer bench: clock, reset, command and
// attribute stimulus, and the final verdict. Uses tccw_pkg, the core and
// console_screen_checker.
`timescale 1ns / 1ps

module tb;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_STOP      = 4;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int BATCHES   = 4;
  localparam int BATCH_LEN = 95;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  tccw_pkg::in_item_t  in_item;
  logic                out_valid;
  tccw_pkg::out_item_t out_item;
  logic                cfg_we;
  logic [7:0]          cfg_wdata;
  int                  mismatch_count;
  int                  reports_owed;
  int                  idle_pct;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_cell_writer_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TAB_STOP     (TAB_STOP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  console_screen_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TAB_STOP     (TAB_STOP)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .reports_owed  (reports_owed)
  );

  // idle a random number of cycles, then hold the command until it transfers
  task automatic issue_command(tccw_pkg::in_item_t c);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(logic [1:0] cmd, logic [7:0] ch, logic [10:0] addr);
    tccw_pkg::in_item_t c;
    c.cmd          = cmd;
    c.char_code    = ch;
    c.read_address = addr;
    issue_command(c);
  endtask

  // drop start and wait until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
  endtask

  task automatic set_attribute(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly characters, with reads near the top and bottom rows and rare clears
  function automatic tccw_pkg::in_item_t draw_command(int newline_pct);
    tccw_pkg::in_item_t c;
    int                 roll;
    c.cmd          = tccw_pkg::CMD_PUT;
    c.char_code    = 8'($urandom_range(0, 255));
    c.read_address = 11'($urandom_range(0, 2047));
    roll = $urandom_range(0, 999);
    if (roll < 10) begin
      c.cmd = tccw_pkg::CMD_CLEAR;
    end else if (roll < 40) begin
      c.cmd = CMD_UNUSED;
    end else if (roll < 260) begin
      c.cmd = tccw_pkg::CMD_READ;
      case ($urandom_range(0, 2))
        0: c.read_address = 11'($urandom_range(0, 2047));
        1: c.read_address = 11'($urandom_range(CELL_COUNT - 5 * SCREEN_WIDTH, CELL_COUNT - 1));
        default: c.read_address = 11'($urandom_range(0, 5 * SCREEN_WIDTH - 1));
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < newline_pct) c.char_code = tccw_pkg::CHAR_NEWLINE;
      else if (roll < newline_pct + 8) c.char_code = tccw_pkg::CHAR_TAB;
    end
    return c;
  endfunction

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int         phase;
    int         batch;
    int         n;
    int         newline_pct;
    logic [7:0] attr_pick;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 16;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the reset sweep of the screen is done
    do @(posedge clk); while (busy);

    // directed: reset contents, extreme bytes, tabs, reads at the edges
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd0);
    issue(tccw_pkg::CMD_PUT, 8'h41, 11'd0);
    issue(tccw_pkg::CMD_PUT, 8'hFF, 11'h7FF);
    issue(tccw_pkg::CMD_PUT, 8'h80, 11'd0);
    issue(tccw_pkg::CMD_PUT, 8'h00, 11'd0);
    issue(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 11'd0);
    issue(tccw_pkg::CMD_PUT, 8'h78, 11'd0);
    issue(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 11'd0);
    issue(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_NEWLINE, 11'd0);
    issue(tccw_pkg::CMD_READ, 8'hFF, 11'd0);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd1);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd2);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd5);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'(CELL_COUNT - 1));
    issue(tccw_pkg::CMD_READ, 8'h00, 11'(CELL_COUNT));
    issue(tccw_pkg::CMD_READ, 8'h00, 11'h7FF);
    issue(CMD_UNUSED, 8'hFF, 11'h7FF);
    issue(tccw_pkg::CMD_CLEAR, 8'hFF, 11'h7FF);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd1);
    issue(tccw_pkg::CMD_PUT, 8'h7F, 11'd0);
    issue(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 11'd0);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd0);
    issue(tccw_pkg::CMD_READ, 8'h00, 11'd3);

    // random batches, attribute changed between them, three idle regimes
    for (phase = 0; phase < 3; phase++) begin
      for (batch = 0; batch < BATCHES; batch++) begin
        settle();
        if (batch == 0) attr_pick = 8'hFF;
        else if (batch == 1) attr_pick = 8'h00;
        else attr_pick = 8'($urandom_range(0, 255));
        set_attribute(attr_pick);
        newline_pct = (batch % 2 == 0) ? 14 : 2;
        for (n = 0; n < BATCH_LEN; n++) begin
          idle_pct = (phase == 0) ? 16 : (phase == 1) ? 75 : 0;
          issue_command(draw_command(newline_pct));
          if ($urandom_range(0, 99) < 2) settle();
        end
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
